### rtl/core/windowed_average_threshold_monitor_defines.svh
// Assertion macros shared by the monitor RTL.
`ifndef WINDOWED_AVERAGE_THRESHOLD_MONITOR_DEFINES_SVH
`define WINDOWED_AVERAGE_THRESHOLD_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define WAVTM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wavtm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define WAVTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wavtm assertion failed");

`endif

### rtl/core/wavtm_pkg.sv
// Package: sizes, payload structs and shared constants of the threshold monitor.
`timescale 1ns / 1ps

package wavtm_pkg;

    // Storage sizing
    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 48;
    localparam int PTR_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;

    // Fixed field widths of the ports
    localparam int FIELD_BITS   = 48;
    localparam int WSUM_BITS    = 54;
    localparam int THR_COUNT    = 10;
    localparam int THR_IDX_BITS = $clog2(THR_COUNT);
    localparam int PCT_BITS     = 7;
    localparam int LEVEL_BITS   = 3;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 35;
    localparam int CFG_WIN_BITS  = 7;
    localparam int CFG_HYST_BITS = 10;

    // Shared multiplier: wide operand taken in two chunks
    localparam int MUL_CHUNK_BITS = (SUM_BITS + 1) / 2;
    localparam int MUL_A_BITS     = 2 * MUL_CHUNK_BITS;
    localparam int MUL_B_BITS     = PCT_BITS + CNT_BITS;
    localparam int MUL_P_BITS     = MUL_CHUNK_BITS + MUL_B_BITS;
    localparam int ACC_BITS       = MUL_A_BITS + MUL_B_BITS;

    localparam logic [MUL_B_BITS-1:0] PCT_SCALE = MUL_B_BITS'(100);

    typedef struct packed {
        logic [FIELD_BITS-1:0] sample_current;
        logic [FIELD_BITS-1:0] sample_total;
    } t_in_item;

    typedef struct packed {
        logic                 notify;
        logic                 average_ready;
        logic [WSUM_BITS-1:0] window_sum;
        logic [THR_COUNT-1:0] asserted_now;
        logic [THR_COUNT-1:0] newly_asserted;
        logic [THR_COUNT-1:0] newly_cleared;
        logic [THR_COUNT-1:0] actions_started;
        logic                 reading_normal;
    } t_out_item;

endpackage

### rtl/core/wavtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wavtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/windowed_average_threshold_monitor.sv
// Top level of the windowed average threshold monitor. Each input transaction carries one
// (current, total) sample; each accepted sample yields exactly one result transaction. The
// block first runs the notify test |cur - last| * 100 >= hyst * last, then pushes the sample
// into a ring of up to 64 entries (one oldest entry dropped per sample once the window is
// full), and, when the ring holds at least window_length samples, checks the enabled ones of
// the ten thresholds in order level 0 lower, level 0 upper, ..., level 4 upper by comparing
// sum * 100 with pct * count * total, all exact. One shared 27x14 multiplier does every
// product, two passes per wide product, under a small sequencer; the block takes no new
// sample while it works. Until the window is full a sample gets only the notify test and
// ring update; once full, the sum product and, per enabled threshold, a total product and
// compare run. A finished result waits in an output register, so the next sample is taken
// while the previous result is still stalled; only a second finished result has to wait.
// The ring store is not cleared at reset: entries are only read after they were written.
// Configuration writes are taken at any cycle but are meant for an idle block.
`timescale 1ns / 1ps

`include "windowed_average_threshold_monitor_defines.svh"

module windowed_average_threshold_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sample channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  wavtm_pkg::t_in_item                   i_in_data,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output wavtm_pkg::t_out_item                  o_out_data,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [wavtm_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [wavtm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SAMPLE_BITS    = wavtm_pkg::SAMPLE_BITS;
    localparam int PTR_BITS       = wavtm_pkg::PTR_BITS;
    localparam int CNT_BITS       = wavtm_pkg::CNT_BITS;
    localparam int SUM_BITS       = wavtm_pkg::SUM_BITS;
    localparam int THR_COUNT      = wavtm_pkg::THR_COUNT;
    localparam int THR_IDX_BITS   = wavtm_pkg::THR_IDX_BITS;
    localparam int PCT_BITS       = wavtm_pkg::PCT_BITS;
    localparam int LEVEL_BITS     = wavtm_pkg::LEVEL_BITS;
    localparam int CFG_IDX_BITS   = wavtm_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS  = wavtm_pkg::CFG_DATA_BITS;
    localparam int CFG_WIN_BITS   = wavtm_pkg::CFG_WIN_BITS;
    localparam int CFG_HYST_BITS  = wavtm_pkg::CFG_HYST_BITS;
    localparam int MUL_CHUNK_BITS = wavtm_pkg::MUL_CHUNK_BITS;
    localparam int MUL_A_BITS     = wavtm_pkg::MUL_A_BITS;
    localparam int MUL_B_BITS     = wavtm_pkg::MUL_B_BITS;
    localparam int MUL_P_BITS     = wavtm_pkg::MUL_P_BITS;
    localparam int ACC_BITS       = wavtm_pkg::ACC_BITS;
    localparam int WSUM_BITS      = wavtm_pkg::WSUM_BITS;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYSTERESIS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE_MASK   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOG_MASK      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTION_MASK   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_PCTS    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_PCTS    = 3'd6;

    localparam logic [THR_IDX_BITS-1:0] THR_LAST = THR_IDX_BITS'(THR_COUNT - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NDIF_LO,   // diff * 100, low chunk
        S_NDIF_HI,   // diff * 100, high chunk -> lhs
        S_NLAST_LO,  // last * hyst, low chunk
        S_NLAST_HI,  // last * hyst, high chunk -> acc
        S_NOTE,      // notify decision, drop oldest, write ring
        S_PUSH,      // add new sample, advance ring
        S_SUM_LO,    // sum * 100, low chunk
        S_SUM_HI,    // sum * 100, high chunk -> lhs
        S_SCALE,     // pct * count, or skip a disabled threshold
        S_TOT_LO,    // total * scale, low chunk
        S_TOT_HI,    // total * scale, high chunk -> acc
        S_EVAL,      // threshold compare and event update
        S_FIN        // hand result to output register
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_WIN_BITS-1:0]  r_cfg_window;
    logic [CFG_HYST_BITS-1:0] r_cfg_hyst;
    logic [THR_COUNT-1:0]     r_cfg_enable;
    logic [THR_COUNT-1:0]     r_cfg_log;
    logic [THR_COUNT-1:0]     r_cfg_action;
    logic [CFG_DATA_BITS-1:0] r_cfg_lower;
    logic [CFG_DATA_BITS-1:0] r_cfg_upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_window <= CFG_WIN_BITS'(1);
            r_cfg_hyst   <= '0;
            r_cfg_enable <= '0;
            r_cfg_log    <= '0;
            r_cfg_action <= '0;
            r_cfg_lower  <= '0;
            r_cfg_upper  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_cfg_window <= CFG_WIN_BITS'(i_cfg_data);
                CFG_HYSTERESIS:    r_cfg_hyst   <= CFG_HYST_BITS'(i_cfg_data);
                CFG_ENABLE_MASK:   r_cfg_enable <= THR_COUNT'(i_cfg_data);
                CFG_LOG_MASK:      r_cfg_log    <= THR_COUNT'(i_cfg_data);
                CFG_ACTION_MASK:   r_cfg_action <= THR_COUNT'(i_cfg_data);
                CFG_LOWER_PCTS:    r_cfg_lower  <= i_cfg_data;
                CFG_UPPER_PCTS:    r_cfg_upper  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective window: zero reads as one, saturates at the ring depth
    logic [CNT_BITS-1:0] win_eff;

    always_comb begin
        if (r_cfg_window == '0) begin
            win_eff = CNT_BITS'(1);
        end else if (int'(r_cfg_window) > wavtm_pkg::WINDOW_MAX) begin
            win_eff = CNT_BITS'(wavtm_pkg::WINDOW_MAX);
        end else begin
            win_eff = CNT_BITS'(r_cfg_window);
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state                  r_state,     n_state;
    logic [THR_IDX_BITS-1:0] r_idx,       n_idx;
    logic [ACC_BITS-1:0]     r_acc,       n_acc;
    logic [ACC_BITS-1:0]     r_lhs,       n_lhs;
    logic [MUL_B_BITS-1:0]   r_scale,     n_scale;
    logic [SUM_BITS-1:0]     r_sum,       n_sum;
    logic [PTR_BITS-1:0]     r_head,      n_head;
    logic [CNT_BITS-1:0]     r_count,     n_count;
    logic [SAMPLE_BITS-1:0]  r_last,      n_last;
    logic [THR_COUNT-1:0]    r_asserted,  n_asserted;
    logic [THR_COUNT-1:0]    r_logged,    n_logged;
    // per-transaction working values
    logic [SAMPLE_BITS-1:0]  r_cur,       n_cur;
    logic [SAMPLE_BITS-1:0]  r_total,     n_total;
    logic [SAMPLE_BITS-1:0]  r_diff,      n_diff;
    logic                    r_drop,      n_drop;
    logic                    r_notify,    n_notify;
    logic                    r_ready,     n_ready;
    logic [THR_COUNT-1:0]    r_new_a,     n_new_a;
    logic [THR_COUNT-1:0]    r_new_c,     n_new_c;
    logic [THR_COUNT-1:0]    r_acts,      n_acts;
    logic                    r_normal,    n_normal;
    // output register
    logic                    r_out_valid, n_out_valid;
    wavtm_pkg::t_out_item    r_out,       n_out;

    logic in_take;
    logic out_take;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_take    = r_out_valid && !i_out_stall;

    // ------------------------------------------------------------------
    // Sample ring
    // ------------------------------------------------------------------
    logic                   ram_we;
    logic                   ram_re;
    logic [PTR_BITS-1:0]    ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_q;
    logic [CNT_BITS:0]      oldest_ext;

    // oldest = head - count, modulo the ring depth
    always_comb begin
        if ((CNT_BITS + 1)'(r_head) >= (CNT_BITS + 1)'(r_count)) begin
            oldest_ext = (CNT_BITS + 1)'(r_head) - (CNT_BITS + 1)'(r_count);
        end else begin
            oldest_ext = (CNT_BITS + 1)'(r_head) + (CNT_BITS + 1)'(wavtm_pkg::WINDOW_MAX)
                         - (CNT_BITS + 1)'(r_count);
        end
    end
    assign ram_raddr = oldest_ext[PTR_BITS-1:0];

    wavtm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (wavtm_pkg::WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (r_cur),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: one chunk of A times B per cycle, accumulated
    // ------------------------------------------------------------------
    logic [MUL_A_BITS-1:0]     mul_a;
    logic [MUL_B_BITS-1:0]     mul_b;
    logic                      mul_hi;
    logic [MUL_CHUNK_BITS-1:0] mul_chunk;
    logic [MUL_P_BITS-1:0]     mul_p;
    logic [ACC_BITS-1:0]       acc_sum;

    // threshold operands
    logic [LEVEL_BITS-1:0] thr_level;
    logic                  thr_upper;
    logic [PCT_BITS-1:0]   thr_pct;
    logic [THR_COUNT-1:0]  thr_bit;

    assign thr_level = LEVEL_BITS'(r_idx >> 1);
    assign thr_upper = r_idx[0];
    assign thr_pct   = thr_upper ? r_cfg_upper[PCT_BITS * thr_level +: PCT_BITS]
                                 : r_cfg_lower[PCT_BITS * thr_level +: PCT_BITS];
    assign thr_bit   = THR_COUNT'(1) << r_idx;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_hi = 1'b0;
        unique case (r_state)
            S_NDIF_LO, S_NDIF_HI: begin
                mul_a  = MUL_A_BITS'(r_diff);
                mul_b  = wavtm_pkg::PCT_SCALE;
                mul_hi = (r_state == S_NDIF_HI);
            end
            S_NLAST_LO, S_NLAST_HI: begin
                mul_a  = MUL_A_BITS'(r_last);
                mul_b  = MUL_B_BITS'(r_cfg_hyst);
                mul_hi = (r_state == S_NLAST_HI);
            end
            S_SUM_LO, S_SUM_HI: begin
                mul_a  = MUL_A_BITS'(r_sum);
                mul_b  = wavtm_pkg::PCT_SCALE;
                mul_hi = (r_state == S_SUM_HI);
            end
            S_SCALE: begin
                mul_a = MUL_A_BITS'(thr_pct);
                mul_b = MUL_B_BITS'(r_count);
            end
            S_TOT_LO, S_TOT_HI: begin
                mul_a  = MUL_A_BITS'(r_total);
                mul_b  = r_scale;
                mul_hi = (r_state == S_TOT_HI);
            end
            default: ;
        endcase
    end

    assign mul_chunk = mul_hi ? mul_a[MUL_A_BITS-1:MUL_CHUNK_BITS]
                              : mul_a[MUL_CHUNK_BITS-1:0];
    assign mul_p     = MUL_P_BITS'(mul_chunk) * MUL_P_BITS'(mul_b);
    assign acc_sum   = r_acc + {mul_p, {MUL_CHUNK_BITS{1'b0}}};

    // One comparator: notify uses lhs < acc; upper thresholds swap sides
    logic                cmp_swap;
    logic [ACC_BITS-1:0] cmp_x;
    logic [ACC_BITS-1:0] cmp_y;
    logic                cmp_lt;

    assign cmp_swap = (r_state == S_EVAL) && thr_upper;
    assign cmp_x    = cmp_swap ? r_acc : r_lhs;
    assign cmp_y    = cmp_swap ? r_lhs : r_acc;
    assign cmp_lt   = (cmp_x < cmp_y);

    logic [THR_COUNT-1:0] logged_cleared;
    logic [CNT_BITS-1:0]  count_pushed;

    assign logged_cleared = r_logged & ~thr_bit;
    // dropping one and pushing one keeps the count
    assign count_pushed   = r_drop ? r_count : r_count + CNT_BITS'(1);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_lhs       = r_lhs;
        n_scale     = r_scale;
        n_sum       = r_sum;
        n_head      = r_head;
        n_count     = r_count;
        n_last      = r_last;
        n_asserted  = r_asserted;
        n_logged    = r_logged;
        n_cur       = r_cur;
        n_total     = r_total;
        n_diff      = r_diff;
        n_drop      = r_drop;
        n_notify    = r_notify;
        n_ready     = r_ready;
        n_new_a     = r_new_a;
        n_new_c     = r_new_c;
        n_acts      = r_acts;
        n_normal    = r_normal;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_cur    = SAMPLE_BITS'(i_in_data.sample_current);
                    n_total  = SAMPLE_BITS'(i_in_data.sample_total);
                    n_diff   = (n_cur >= r_last) ? n_cur - r_last : r_last - n_cur;
                    n_drop   = (r_count >= win_eff);
                    ram_re   = 1'b1;   // fetch oldest sample
                    n_notify = 1'b0;
                    n_ready  = 1'b0;
                    n_new_a  = '0;
                    n_new_c  = '0;
                    n_acts   = '0;
                    n_normal = 1'b0;
                    n_state  = S_NDIF_LO;
                end
            end
            S_NDIF_LO: begin
                n_acc   = ACC_BITS'(mul_p);
                n_state = S_NDIF_HI;
            end
            S_NDIF_HI: begin
                n_lhs   = acc_sum;
                n_state = S_NLAST_LO;
            end
            S_NLAST_LO: begin
                n_acc   = ACC_BITS'(mul_p);
                n_state = S_NLAST_HI;
            end
            S_NLAST_HI: begin
                n_acc   = acc_sum;
                n_state = S_NOTE;
            end
            S_NOTE: begin
                n_notify = !cmp_lt;
                if (!cmp_lt) begin
                    n_last = r_cur;
                end
                if (r_drop) begin
                    n_sum = r_sum - SUM_BITS'(ram_q);
                end
                ram_we  = 1'b1;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                n_sum   = r_sum + SUM_BITS'(r_cur);
                n_head  = (r_head == PTR_BITS'(wavtm_pkg::WINDOW_MAX - 1))
                          ? '0 : r_head + PTR_BITS'(1);
                n_count = count_pushed;
                n_idx   = '0;
                if (count_pushed >= win_eff) begin
                    n_ready = 1'b1;
                    n_state = S_SUM_LO;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SUM_LO: begin
                n_acc   = ACC_BITS'(mul_p);
                n_state = S_SUM_HI;
            end
            S_SUM_HI: begin
                n_lhs   = acc_sum;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                if ((r_cfg_enable & thr_bit) != '0) begin
                    n_scale = MUL_B_BITS'(mul_p);
                    n_state = S_TOT_LO;
                end else if (r_idx == THR_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + THR_IDX_BITS'(1);
                end
            end
            S_TOT_LO: begin
                n_acc   = ACC_BITS'(mul_p);
                n_state = S_TOT_HI;
            end
            S_TOT_HI: begin
                n_acc   = acc_sum;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                // cmp_lt is the violation for either bound here
                if (cmp_lt) begin
                    if ((r_asserted & thr_bit) == '0) begin
                        n_asserted = r_asserted | thr_bit;
                        n_new_a    = r_new_a | thr_bit;
                        if ((r_cfg_log & thr_bit) != '0) begin
                            n_logged = r_logged | thr_bit;
                        end
                        if ((r_cfg_action & thr_bit) != '0) begin
                            n_acts = r_acts | thr_bit;
                        end
                    end
                end else if ((r_asserted & thr_bit) != '0) begin
                    n_asserted = r_asserted & ~thr_bit;
                    n_new_c    = r_new_c | thr_bit;
                    if ((r_cfg_log & thr_bit) != '0) begin
                        n_logged = logged_cleared;
                        if (logged_cleared == '0) begin
                            n_normal = 1'b1;
                        end
                    end
                end
                if (r_idx == THR_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_idx   = r_idx + THR_IDX_BITS'(1);
                    n_state = S_SCALE;
                end
            end
            S_FIN: begin
                // load only when the output register is free or draining
                if (!r_out_valid || !i_out_stall) begin
                    n_out.notify          = r_notify;
                    n_out.average_ready   = r_ready;
                    n_out.window_sum      = WSUM_BITS'(r_sum);
                    n_out.asserted_now    = r_asserted;
                    n_out.newly_asserted  = r_new_a;
                    n_out.newly_cleared   = r_new_c;
                    n_out.actions_started = r_acts;
                    n_out.reading_normal  = r_normal;
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_last      <= '0;
            r_asserted  <= '0;
            r_logged    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_head      <= n_head;
            r_count     <= n_count;
            r_last      <= n_last;
            r_asserted  <= n_asserted;
            r_logged    <= n_logged;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_lhs    <= n_lhs;
        r_scale  <= n_scale;
        r_cur    <= n_cur;
        r_total  <= n_total;
        r_diff   <= n_diff;
        r_drop   <= n_drop;
        r_notify <= n_notify;
        r_ready  <= n_ready;
        r_new_a  <= n_new_a;
        r_new_c  <= n_new_c;
        r_acts   <= n_acts;
        r_normal <= n_normal;
        r_out    <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic chk_count_ok;
    logic chk_disjoint;
    logic chk_act_subset;
    logic out_unready;
    logic chk_quiet;

    assign chk_count_ok   = (r_count <= CNT_BITS'(wavtm_pkg::WINDOW_MAX));
    assign chk_disjoint   = ((r_out.newly_asserted & r_out.newly_cleared) == '0);
    assign chk_act_subset = ((r_out.actions_started & ~r_out.newly_asserted) == '0);
    assign out_unready    = r_out_valid && !r_out.average_ready;
    assign chk_quiet      = ((r_out.newly_asserted | r_out.newly_cleared) == '0)
                            && !r_out.reading_normal;

    `WAVTM_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, chk_count_ok)
    `WAVTM_ASSERT_NOW(a_events_disjoint, i_clk, i_rst_n, r_out_valid, chk_disjoint)
    `WAVTM_ASSERT_NOW(a_actions_subset, i_clk, i_rst_n, r_out_valid, chk_act_subset)
    `WAVTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall)
    `WAVTM_ASSERT_NOW(a_idle_when_not_ready, i_clk, i_rst_n, out_unready, chk_quiet)

endmodule
